// ===== rtl/kmd_pkg.sv =====
package kmd_pkg;

	localparam int ROWS = 8;
	localparam int COLS = 8;
	localparam int MATRIX_BITS = ROWS * COLS;
	localparam int SCAN_W = 64;
	localparam int KEY_W = 6;
	localparam int CFG_W = 8;

	localparam logic [SCAN_W-1:0] MATRIX_MASK = (MATRIX_BITS >= SCAN_W) ? {SCAN_W{1'b1}} :
		((SCAN_W'(1) << MATRIX_BITS) - SCAN_W'(1));

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd2;
	localparam logic [CFG_W-1:0] STAMP_WRAP = 8'hFF;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic accept;
		logic shift;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic fire;
		logic diff_zero;
		logic bit0;
	} status_t;

endpackage

// ===== rtl/key_matrix_debounce_event_emitter.sv =====
// Key matrix scanner with one global debounce timer and change events.
// The input channel (in_valid, in_ready, scan_bits) takes one full matrix
// snapshot per transfer. The output channel (out_valid, out_ready) gives one
// event per changed key: key_id, pressed, stamp and last, in ascending key
// order, with last set on the final event of a scan. The config channel
// (cfg_valid, cfg_ready, cfg_data) sets the number of stable scans needed;
// a write of zero is stored as one. It is always ready.
// A snapshot that reports no change needs no walk. A snapshot that ends the
// debounce period is followed by a bit-serial walk of the difference image,
// one key position per cycle unless the receiver stalls; the walk stops
// early once no changed keys remain.
// The next snapshot is accepted while the final event still waits in the
// output register. When the receiver stalls, the walk pauses at the next
// changed key. Reset clears the images and the stamp and loads the debounce
// setting and countdown with two.
module key_matrix_debounce_event_emitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kmd_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [kmd_pkg::SCAN_W-1:0]        scan_bits,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kmd_pkg::KEY_W-1:0]         key_id,
	output logic                              pressed,
	output logic [kmd_pkg::CFG_W-1:0]         stamp,
	output logic                              last
);
	import kmd_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	kmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	kmd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.scan_bits (scan_bits),
		.cmd       (cmd),
		.st        (st),
		.key_id    (key_id),
		.pressed   (pressed),
		.stamp     (stamp),
		.last      (last)
	);

	// No changed keys are left over whenever a new snapshot can be taken.
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> st.diff_zero)
		else $error("difference image not empty while ready for a snapshot");

	// A pending event is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("event loaded over a pending event");

	// A snapshot that releases events blocks the input while they are walked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && st.fire) |=> !in_ready)
		else $error("input ready while events are pending");

endmodule

// ===== rtl/kmd_ctrl.sv =====
module kmd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  kmd_pkg::status_t st,
	output kmd_pkg::cmd_t    cmd
);
	import kmd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.fire) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (st.diff_zero) begin
					state_d = ST_IDLE;
				end else if (!st.bit0) begin
					cmd.shift = 1'b1;
				end else if (out_free) begin
					cmd.shift = 1'b1;
					cmd.load_out = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/kmd_dp.sv =====
module kmd_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [kmd_pkg::CFG_W-1:0]    cfg_data,
	input  logic [kmd_pkg::SCAN_W-1:0]   scan_bits,
	input  kmd_pkg::cmd_t                cmd,
	output kmd_pkg::status_t             st,
	output logic [kmd_pkg::KEY_W-1:0]    key_id,
	output logic                         pressed,
	output logic [kmd_pkg::CFG_W-1:0]    stamp,
	output logic                         last
);
	import kmd_pkg::*;

	logic [CFG_W-1:0]  debounce_q;
	logic [SCAN_W-1:0] raw_q;
	logic [SCAN_W-1:0] rep_q;
	logic [CFG_W-1:0]  count_q;
	logic [CFG_W-1:0]  stamp_q;
	logic [SCAN_W-1:0] diff_q;
	logic [SCAN_W-1:0] val_q;
	logic [KEY_W-1:0]  idx_q;
	logic [CFG_W-1:0]  ev_stamp_q;
	logic [KEY_W-1:0]  key_id_q;
	logic              pressed_q;
	logic [CFG_W-1:0]  stamp_out_q;
	logic              last_q;

	logic [SCAN_W-1:0] snap;
	logic [SCAN_W-1:0] diff_new;
	logic [CFG_W-1:0]  cnt_ld;
	logic [CFG_W-1:0]  stamp_inc;
	logic              expire;

	assign snap = scan_bits & MATRIX_MASK;
	assign cnt_ld = (snap != raw_q) ? debounce_q : count_q;
	assign expire = (cnt_ld == CFG_W'(1));
	assign diff_new = rep_q ^ snap;
	assign stamp_inc = stamp_q + CFG_W'(1);

	assign st.fire = expire && (diff_new != '0);
	assign st.diff_zero = (diff_q == '0);
	assign st.bit0 = diff_q[0];

	assign key_id = key_id_q;
	assign pressed = pressed_q;
	assign stamp = stamp_out_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			raw_q <= '0;
			rep_q <= '0;
			count_q <= DEBOUNCE_RESET;
			stamp_q <= '0;
			diff_q <= '0;
		end else begin
			if (cfg_valid) begin
				debounce_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
			end
			if (cmd.accept) begin
				raw_q <= snap;
				count_q <= (cnt_ld != '0) ? cnt_ld - CFG_W'(1) : '0;
				stamp_q <= (stamp_inc == STAMP_WRAP) ? '0 : stamp_inc;
				if (expire) begin
					rep_q <= snap;
					diff_q <= diff_new;
				end
			end else if (cmd.shift) begin
				diff_q <= diff_q >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= snap;
			idx_q <= '0;
			ev_stamp_q <= stamp_q;
		end else if (cmd.shift) begin
			val_q <= val_q >> 1;
			idx_q <= idx_q + KEY_W'(1);
		end
		if (cmd.load_out) begin
			key_id_q <= idx_q;
			pressed_q <= val_q[0];
			stamp_out_q <= ev_stamp_q;
			last_q <= (diff_q[SCAN_W-1:1] == '0);
		end
	end

endmodule
